@@ rtl/dpb_pkg.sv @@
// ----------------------------------------------------------------------------
// dpb_pkg
// widths, register map, reset values and helper functions shared by the
// depth pixel back-projection block and its channel interfaces
// ----------------------------------------------------------------------------
`default_nettype none

package dpb_pkg;

  localparam int MAX_DIM     = 4096;
  localparam int RAW_W       = 16;
  localparam int COORD_W     = 12;
  localparam int POINT_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int RECIP_W     = 32;
  localparam int CENTER_W    = 28;
  localparam int MAXD_W      = 31;
  localparam int FRAC_W      = 16;

  localparam int DPROD_W     = RAW_W + RECIP_W;           // raw * inv_depth_scale
  localparam int ZFULL_W     = DPROD_W - 8;               // z before range test
  localparam int ZVAL_W      = MAXD_W;                    // z once in range
  localparam int M1_W        = CENTER_W + ZVAL_W;         // |d| * z
  localparam int M1_HI_W     = M1_W - 32;
  localparam int HI_W        = M1_HI_W + RECIP_W;
  localparam int SUM_W       = HI_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_DEPTH_SCALE = 3'd0,
    REG_INV_FOCAL_X     = 3'd1,
    REG_INV_FOCAL_Y     = 3'd2,
    REG_CENTER_X        = 3'd3,
    REG_CENTER_Y        = 3'd4,
    REG_MAX_DEPTH       = 3'd5
  } cfg_reg_t;

  localparam logic [RECIP_W-1:0]  RST_INV_DEPTH_SCALE = 32'd16777;
  localparam logic [RECIP_W-1:0]  RST_INV_FOCAL       = 32'd33554;
  localparam logic [CENTER_W-1:0] RST_CENTER_X        = 28'd20971520;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y        = 28'd15728640;
  localparam logic [MAXD_W-1:0]   RST_MAX_DEPTH       = 31'd196608;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
    logic [COORD_W-1:0] res;
    if (32'(c) >= MAX_DIM) begin
      res = COORD_W'(MAX_DIM - 1);
    end else begin
      res = c;
    end
    return res;
  endfunction

  // q.24 sum down to q16.16, saturated after truncation, then the sign is applied
  function automatic logic signed [POINT_W-1:0] project_sat(input logic [SUM_W-1:0] s,
                                                            input logic neg);
    logic [SUM_W-9:0]       r;
    logic [POINT_W-1:0]     mag;
    logic signed [POINT_W-1:0] res;
    r = s[SUM_W-1:8];
    if (neg) begin
      if (r > (SUM_W-8)'(64'h8000_0000)) begin
        mag = 32'h8000_0000;
      end else begin
        mag = r[POINT_W-1:0];
      end
      res = signed'(32'd0 - mag);
    end else begin
      if (r > (SUM_W-8)'(64'h7FFF_FFFF)) begin
        res = 32'sh7FFF_FFFF;
      end else begin
        res = signed'(r[POINT_W-1:0]);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dpb_if.sv @@
// ----------------------------------------------------------------------------
// dpb channel interfaces
// pixel, point and configuration write channels, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface dpb_pixel_if;
  import dpb_pkg::*;
  logic               valid;
  logic               ready;
  logic [RAW_W-1:0]   raw_depth;
  logic [COORD_W-1:0] pixel_row;
  logic [COORD_W-1:0] pixel_col;
  logic               last_pixel;

  modport source (output valid, raw_depth, pixel_row, pixel_col, last_pixel, input ready);
  modport sink   (input valid, raw_depth, pixel_row, pixel_col, last_pixel, output ready);
endinterface

interface dpb_point_if;
  import dpb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic signed [POINT_W-1:0] point_z;
  logic                      point_valid;
  logic                      last_point;

  modport source (output valid, point_x, point_y, point_z, point_valid, last_point,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_valid, last_point,
                  output ready);
endinterface

interface dpb_cfg_if;
  import dpb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/depth_pixel_backprojection_top.sv @@
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_top
// path: an accepted pixel beat passes the stage 1 to 3 registers, then the output register
// throughput: one pixel per cycle; all four stages advance together and hold
//   as one while a finished point waits on the output register
// reset: synchronous active-low rst_n clears the stage valid bits and loads the
//   default intrinsics; configuration writes are always taken
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_backprojection_top (
  input  wire               clk,
  input  wire               rst_n,
  dpb_cfg_if.sink           cfg_wr,
  dpb_pixel_if.sink         in_pix,
  dpb_point_if.source       out_pt
);
  import dpb_pkg::*;

  // configuration
  logic [RECIP_W-1:0]  inv_depth_scale_r;
  logic [RECIP_W-1:0]  inv_focal_x_r;
  logic [RECIP_W-1:0]  inv_focal_y_r;
  logic [CENTER_W-1:0] center_x_r;
  logic [CENTER_W-1:0] center_y_r;
  logic [MAXD_W-1:0]   max_depth_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_depth_scale_r <= RST_INV_DEPTH_SCALE;
      inv_focal_x_r     <= RST_INV_FOCAL;
      inv_focal_y_r     <= RST_INV_FOCAL;
      center_x_r        <= RST_CENTER_X;
      center_y_r        <= RST_CENTER_Y;
      max_depth_r       <= RST_MAX_DEPTH;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_INV_DEPTH_SCALE: inv_depth_scale_r <= cfg_wr.data;
        REG_INV_FOCAL_X:     inv_focal_x_r     <= cfg_wr.data;
        REG_INV_FOCAL_Y:     inv_focal_y_r     <= cfg_wr.data;
        REG_CENTER_X:        center_x_r        <= cfg_wr.data[CENTER_W-1:0];
        REG_CENTER_Y:        center_y_r        <= cfg_wr.data[CENTER_W-1:0];
        REG_MAX_DEPTH:       max_depth_r       <= cfg_wr.data[MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline enable: everything moves unless the output beat is stalled
  logic en;
  logic out_valid_r;
  assign en           = !out_valid_r || out_pt.ready;
  assign in_pix.ready = en;

  // stage 1: depth product, pixel offsets from the principal point
  logic                v1_r;
  logic [DPROD_W-1:0]  dprod1_r;
  logic [CENTER_W-1:0] magx1_r, magy1_r;
  logic                negx1_r, negy1_r;
  logic                last1_r;

  logic [COORD_W-1:0]  col_c, row_c;
  logic [CENTER_W-1:0] posx, posy;
  logic                negx_nxt, negy_nxt;
  logic [CENTER_W-1:0] magx_nxt, magy_nxt;
  logic [DPROD_W-1:0]  dprod_nxt;

  always_comb begin
    col_c     = clamp_coord(in_pix.pixel_col);
    row_c     = clamp_coord(in_pix.pixel_row);
    posx      = {col_c, FRAC_W'(0)};
    posy      = {row_c, FRAC_W'(0)};
    negx_nxt  = posx < center_x_r;
    negy_nxt  = posy < center_y_r;
    magx_nxt  = negx_nxt ? (center_x_r - posx) : (posx - center_x_r);
    magy_nxt  = negy_nxt ? (center_y_r - posy) : (posy - center_y_r);
    dprod_nxt = DPROD_W'(in_pix.raw_depth) * DPROD_W'(inv_depth_scale_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dprod1_r <= dprod_nxt;
      magx1_r  <= magx_nxt;
      magy1_r  <= magy_nxt;
      negx1_r  <= negx_nxt;
      negy1_r  <= negy_nxt;
      last1_r  <= in_pix.last_pixel;
    end
  end

  // stage 2: range test on z, |d| * z
  logic               v2_r;
  logic               ok2_r;
  logic [ZVAL_W-1:0]  z2_r;
  logic [M1_W-1:0]    mx2_r, my2_r;
  logic               negx2_r, negy2_r;
  logic               last2_r;

  logic [ZFULL_W-1:0] zfull;
  logic               ok_nxt;
  logic [M1_W-1:0]    mx_nxt, my_nxt;

  always_comb begin
    zfull  = dprod1_r[DPROD_W-1:8];
    ok_nxt = (zfull != '0) && (zfull < ZFULL_W'(max_depth_r));
    mx_nxt = M1_W'(magx1_r) * M1_W'(zfull[ZVAL_W-1:0]);
    my_nxt = M1_W'(magy1_r) * M1_W'(zfull[ZVAL_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok2_r   <= ok_nxt;
      z2_r    <= zfull[ZVAL_W-1:0];
      mx2_r   <= mx_nxt;
      my2_r   <= my_nxt;
      negx2_r <= negx1_r;
      negy2_r <= negy1_r;
      last2_r <= last1_r;
    end
  end

  // stage 3: split products by the reciprocal focal lengths
  logic              v3_r;
  logic              ok3_r;
  logic [ZVAL_W-1:0] z3_r;
  logic [HI_W-1:0]   hix3_r, hiy3_r;
  logic [31:0]       lox3_r, loy3_r;
  logic              negx3_r, negy3_r;
  logic              last3_r;

  logic [HI_W-1:0]   hix_nxt, hiy_nxt;
  logic [63:0]       lox_full, loy_full;

  always_comb begin
    hix_nxt  = HI_W'(mx2_r[M1_W-1:32]) * HI_W'(inv_focal_x_r);
    hiy_nxt  = HI_W'(my2_r[M1_W-1:32]) * HI_W'(inv_focal_y_r);
    lox_full = 64'(mx2_r[31:0]) * 64'(inv_focal_x_r);
    loy_full = 64'(my2_r[31:0]) * 64'(inv_focal_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok3_r   <= ok2_r;
      z3_r    <= z2_r;
      hix3_r  <= hix_nxt;
      hiy3_r  <= hiy_nxt;
      lox3_r  <= lox_full[63:32];
      loy3_r  <= loy_full[63:32];
      negx3_r <= negx2_r;
      negy3_r <= negy2_r;
      last3_r <= last2_r;
    end
  end

  // stage 4: sum, truncate, saturate (zero if out of range) into the output register
  logic signed [POINT_W-1:0] px_r, py_r, pz_r;
  logic                      pvalid_r, plast_r;
  logic [SUM_W-1:0]          sx, sy;
  logic signed [POINT_W-1:0] px_nxt, py_nxt, pz_nxt;

  always_comb begin
    sx     = SUM_W'(hix3_r) + SUM_W'(lox3_r);
    sy     = SUM_W'(hiy3_r) + SUM_W'(loy3_r);
    px_nxt = ok3_r ? project_sat(sx, negx3_r) : '0;
    py_nxt = ok3_r ? project_sat(sy, negy3_r) : '0;
    pz_nxt = ok3_r ? signed'(POINT_W'(z3_r)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      pz_r     <= pz_nxt;
      pvalid_r <= ok3_r;
      plast_r  <= last3_r;
    end
  end

  assign out_pt.valid       = out_valid_r;
  assign out_pt.point_x     = px_r;
  assign out_pt.point_y     = py_r;
  assign out_pt.point_z     = pz_r;
  assign out_pt.point_valid = pvalid_r;
  assign out_pt.last_point  = plast_r;

`ifndef SYNTH
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pt.ready) |-> !in_pix.ready)
    else $error("input taken while output beat stalled");

  a_invalid_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pt.valid && !out_pt.point_valid) |->
      (out_pt.point_x == 0 && out_pt.point_y == 0 && out_pt.point_z == 0))
    else $error("out of range point not zeroed");

  a_valid_z_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pt.valid && out_pt.point_valid) |-> (out_pt.point_z > 0))
    else $error("valid point with non-positive depth");

  a_pixel_reaches_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> v1_r)
    else $error("accepted pixel lost in first stage");
`endif

endmodule

`default_nettype wire
